### hdl/mke_pkg.sv
// Shared constants, key-profile tables and elaboration-time profile math
// for the musical key estimator. No dependencies.
package mke_pkg;

    localparam int CHROMA_BITS_DEF       = 32;
    localparam int PROFILE_FRAC_BITS_DEF = 16;
    localparam int IN_W        = 32;
    localparam int NUM_BINS    = 12;
    localparam int NUM_LANES   = 24;
    localparam int LANE_IDX_W  = 5;
    localparam int SCALE_TOP   = 19;
    localparam int C_W         = 20;
    localparam int SQ_W        = 44;
    localparam int N_W         = 22;
    localparam int SQRT_STAGES = 11;
    localparam int Q_BITS      = 17;
    localparam int CONF_W      = 16;
    localparam int CONF_MAX    = 32768;

    localparam logic [9:0] MAJOR_HUND [NUM_BINS] = '{10'd635, 10'd223, 10'd348, 10'd233,
        10'd438, 10'd409, 10'd252, 10'd519, 10'd239, 10'd366, 10'd229, 10'd288};
    localparam logic [9:0] MINOR_HUND [NUM_BINS] = '{10'd633, 10'd268, 10'd352, 10'd538,
        10'd260, 10'd353, 10'd254, 10'd475, 10'd398, 10'd269, 10'd334, 10'd317};

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = v;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = 65'd0;
        quo = 64'd0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] prof_q(input int minor, input int idx, input int frac);
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] h;
        logic [63:0] num;
        s = 64'd0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            h = (minor != 0) ? 64'(MINOR_HUND[i]) : 64'(MAJOR_HUND[i]);
            s = s + h * h;
        end
        r   = isqrt64(s << 40);
        h   = (minor != 0) ? 64'(MINOR_HUND[idx]) : 64'(MAJOR_HUND[idx]);
        num = (h << (frac + 20)) + (r >> 1);
        return udiv64(num, r);
    endfunction

endpackage

### hdl/mke_lane.sv
// One correlation lane: dot product of the scaled chroma with one rotated
// key profile, three register stages. Depends on mke_pkg.
module mke_lane import mke_pkg::*; #(
    parameter int ROOT  = 0,
    parameter int MINOR = 0,
    parameter int FRAC  = PROFILE_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [C_W-1:0]        c [NUM_BINS],
    output logic [C_W+FRAC+3:0]   score
);

    localparam int P_W = C_W + FRAC;
    localparam int G_W = P_W + 2;
    localparam int S_W = P_W + 4;

    logic [P_W-1:0] prod_reg [NUM_BINS];
    logic [G_W-1:0] grp_reg  [4];
    logic [S_W-1:0] sum_reg;

    for (genvar i = 0; i < NUM_BINS; i++)
    begin : g_prod
        localparam logic [FRAC-1:0] QV =
            FRAC'(prof_q(MINOR, (i + NUM_BINS - ROOT) % NUM_BINS, FRAC));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[i] <= P_W'(c[i]) * P_W'(QV);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < 4; g++)
            begin
                grp_reg[g] <= G_W'(prod_reg[3*g]) + G_W'(prod_reg[3*g+1])
                            + G_W'(prod_reg[3*g+2]);
            end
            sum_reg <= S_W'(grp_reg[0]) + S_W'(grp_reg[1])
                     + S_W'(grp_reg[2]) + S_W'(grp_reg[3]);
        end
    end

    assign score = sum_reg;

endmodule

### hdl/mke_merge.sv
// Merge stage: picks the first best of the lane scores through a two-stage
// compare tree, carrying a sideband alongside. Depends on mke_pkg.
module mke_merge import mke_pkg::*; #(
    parameter int S_W    = 40,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [S_W-1:0]        score [NUM_LANES],
    input  logic [SIDE_W-1:0]     side_in,
    output logic [S_W-1:0]        best,
    output logic [LANE_IDX_W-1:0] best_idx,
    output logic [SIDE_W-1:0]     side_out
);

    logic [S_W-1:0]        l1_s [12];
    logic [LANE_IDX_W-1:0] l1_i [12];
    logic [S_W-1:0]        l2_s [6];
    logic [LANE_IDX_W-1:0] l2_i [6];
    logic [S_W-1:0]        a_s_reg [6];
    logic [LANE_IDX_W-1:0] a_i_reg [6];
    logic [SIDE_W-1:0]     a_side_reg;
    logic [S_W-1:0]        b_s [5];
    logic [LANE_IDX_W-1:0] b_i [5];
    logic [S_W-1:0]        best_reg;
    logic [LANE_IDX_W-1:0] idx_reg;
    logic [SIDE_W-1:0]     side_reg;

    always_comb
    begin
        for (int j = 0; j < 12; j++)
        begin
            if (score[2*j+1] > score[2*j])
            begin
                l1_s[j] = score[2*j+1];
                l1_i[j] = LANE_IDX_W'(2*j+1);
            end
            else
            begin
                l1_s[j] = score[2*j];
                l1_i[j] = LANE_IDX_W'(2*j);
            end
        end
        for (int j = 0; j < 6; j++)
        begin
            if (l1_s[2*j+1] > l1_s[2*j])
            begin
                l2_s[j] = l1_s[2*j+1];
                l2_i[j] = l1_i[2*j+1];
            end
            else
            begin
                l2_s[j] = l1_s[2*j];
                l2_i[j] = l1_i[2*j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s_reg    <= l2_s;
            a_i_reg    <= l2_i;
            a_side_reg <= side_in;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (a_s_reg[2*j+1] > a_s_reg[2*j])
            begin
                b_s[j] = a_s_reg[2*j+1];
                b_i[j] = a_i_reg[2*j+1];
            end
            else
            begin
                b_s[j] = a_s_reg[2*j];
                b_i[j] = a_i_reg[2*j];
            end
        end
        if (b_s[1] > b_s[0])
        begin
            b_s[3] = b_s[1];
            b_i[3] = b_i[1];
        end
        else
        begin
            b_s[3] = b_s[0];
            b_i[3] = b_i[0];
        end
        if (b_s[2] > b_s[3])
        begin
            b_s[4] = b_s[2];
            b_i[4] = b_i[2];
        end
        else
        begin
            b_s[4] = b_s[3];
            b_i[4] = b_i[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_reg <= b_s[4];
            idx_reg  <= b_i[4];
            side_reg <= a_side_reg;
        end
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;
    assign side_out = side_reg;

endmodule

### hdl/mke_sqrt.sv
// Pipelined integer square root, two result bits per stage, with a
// sideband that travels alongside. Depends on mke_pkg.
module mke_sqrt import mke_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   x,
    input  logic [SIDE_W-1:0] side_in,
    output logic [N_W-1:0]    root,
    output logic [SIDE_W-1:0] side_out
);

    logic [SQ_W-1:0]   x_reg    [SQRT_STAGES];
    logic [SQ_W-1:0]   res_reg  [SQRT_STAGES];
    logic [SIDE_W-1:0] side_reg [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        logic [SQ_W-1:0]   x_prev;
        logic [SQ_W-1:0]   res_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [SQ_W-1:0]   xv;
        logic [SQ_W-1:0]   rv;
        logic [SQ_W-1:0]   b;

        if (s == 0)
        begin : g_first
            assign x_prev    = x;
            assign res_prev  = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign x_prev    = x_reg[s-1];
            assign res_prev  = res_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_comb
        begin
            xv = x_prev;
            rv = res_prev;
            b  = '0;
            for (int t = 0; t < 2; t++)
            begin
                b = SQ_W'(1) << (SQ_W - 2 - 2 * (2 * s + t));
                if (xv >= rv + b)
                begin
                    xv = xv - (rv + b);
                    rv = (rv >> 1) + b;
                end
                else
                begin
                    rv = rv >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= xv;
                res_reg[s]  <= rv;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign root     = res_reg[SQRT_STAGES-1][N_W-1:0];
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

### hdl/mke_div.sv
// Pipelined restoring divider for the confidence, one quotient bit per
// stage, saturated at one in Q1.15. Depends on mke_pkg.
module mke_div import mke_pkg::*; #(
    parameter int B_W    = 40,
    parameter int FRAC   = PROFILE_FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic [B_W-1:0]    best,
    input  logic [N_W-1:0]    nrm,
    input  logic [SIDE_W-1:0] side_in,
    output logic [CONF_W-1:0] conf,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NUM_W = B_W + 15;

    logic [NUM_W-1:0]  rem_reg  [Q_BITS];
    logic [N_W-1:0]    n_reg    [Q_BITS];
    logic [Q_BITS-1:0] q_reg    [Q_BITS];
    logic [SIDE_W-1:0] side_reg [Q_BITS];

    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_stage
        localparam int J = Q_BITS - 1 - s;
        logic [NUM_W-1:0]  rem_prev;
        logic [N_W-1:0]    n_prev;
        logic [Q_BITS-1:0] q_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [NUM_W-1:0]  dsh;

        if (s == 0)
        begin : g_first
            assign rem_prev  = {best, 15'd0};
            assign n_prev    = nrm;
            assign q_prev    = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[s-1];
            assign n_prev    = n_reg[s-1];
            assign q_prev    = q_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        assign dsh = NUM_W'(n_prev) << (FRAC + J);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_prev >= dsh)
                begin
                    rem_reg[s] <= rem_prev - dsh;
                    q_reg[s]   <= q_prev | (Q_BITS'(1) << J);
                end
                else
                begin
                    rem_reg[s] <= rem_prev;
                    q_reg[s]   <= q_prev;
                end
                n_reg[s]    <= n_prev;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign conf = (q_reg[Q_BITS-1] > Q_BITS'(CONF_MAX)) ? CONF_W'(CONF_MAX)
                                                         : q_reg[Q_BITS-1][CONF_W-1:0];
    assign side_out = side_reg[Q_BITS-1];

endmodule

### hdl/musical_key_estimator.sv
// Musical key estimator top level: input and scaling stages, 24 correlation
// lanes, merge, norm and confidence pipelines.
// Depends on mke_pkg, mke_lane, mke_merge, mke_sqrt, mke_div.
//
// Usage: one 12-bin chroma vector enters per beat on the s_ channel; one key
// estimate leaves per vector on the m_ channel, in order.
// A vector passes 36 register stages from the accepting edge to m_tvalid:
// input, max, scale (3), lane products and adder tree (3), merge tree (2),
// square root at two bits a stage (11) and the restoring divider at one
// quotient bit a stage (17).
// Throughput is one vector per cycle while the receiver does not stall: all
// 24 key candidates are scored by their own lane in the same cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; it rises again on the beat that drains the output.
// Reset clears all valid flags; no result is presented after reset until a
// vector has passed through. An all-zero vector gives a result of zeros.
module musical_key_estimator import mke_pkg::*; #(
    parameter int CHROMA_BITS       = CHROMA_BITS_DEF,
    parameter int PROFILE_FRAC_BITS = PROFILE_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // chroma_c, chroma_cs, chroma_d, chroma_ds, chroma_e, chroma_f,
    // chroma_fs, chroma_g, chroma_gs, chroma_a, chroma_as, chroma_b
    input  logic [NUM_BINS*IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // key_found, key_root, key_minor, key_confidence, zero pad
    output logic [23:0]              m_tdata
);

    localparam int X_W   = (CHROMA_BITS < IN_W) ? CHROMA_BITS : IN_W;
    localparam int TOP_W = $clog2(X_W);
    localparam int B_W   = C_W + PROFILE_FRAC_BITS + 4;
    localparam int LAT   = 3 + 3 + 2 + SQRT_STAGES + Q_BITS;
    localparam int SQR_W = 2 * C_W;
    localparam int SG_W  = SQR_W + 2;

    logic              en;
    logic [LAT-1:0]    vld_reg;

    logic [X_W-1:0]    in_reg  [NUM_BINS];
    logic [X_W-1:0]    mx_reg  [NUM_BINS];
    logic [X_W-1:0]    maxv_reg;
    logic [X_W-1:0]    m1 [6];
    logic [X_W-1:0]    m2 [3];
    logic [X_W-1:0]    m3;
    logic [TOP_W-1:0]  top;
    logic [C_W-1:0]    c_reg   [NUM_BINS];
    logic              found_reg;
    logic [2:0]        fd_reg;

    logic [SQR_W-1:0]  sq_reg  [NUM_BINS];
    logic [SG_W-1:0]   sg_reg  [4];
    logic [SQ_W-1:0]   sumsq_reg;

    logic [B_W-1:0]    score [NUM_LANES];
    logic [B_W-1:0]    best;
    logic [LANE_IDX_W-1:0] best_idx;
    logic [SQ_W:0]     mg_side;

    logic [N_W-1:0]    nrm;
    logic [LANE_IDX_W+B_W:0] sq_side;
    logic [CONF_W-1:0] conf;
    logic [LANE_IDX_W:0] dv_side;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                in_reg[i] <= s_tdata[i*IN_W +: X_W];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            m1[j] = (in_reg[2*j+1] > in_reg[2*j]) ? in_reg[2*j+1] : in_reg[2*j];
        end
        for (int j = 0; j < 3; j++)
        begin
            m2[j] = (m1[2*j+1] > m1[2*j]) ? m1[2*j+1] : m1[2*j];
        end
        m3 = (m2[1] > m2[0]) ? m2[1] : m2[0];
        m3 = (m2[2] > m3) ? m2[2] : m3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= in_reg;
            maxv_reg <= m3;
        end
    end

    always_comb
    begin
        top = '0;
        for (int b = 0; b < X_W; b++)
        begin
            if (maxv_reg[b])
            begin
                top = TOP_W'(b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                c_reg[i] <= C_W'({mx_reg[i], {SCALE_TOP{1'b0}}} >> top);
            end
            found_reg <= (maxv_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                sq_reg[i] <= SQR_W'(c_reg[i]) * SQR_W'(c_reg[i]);
            end
            for (int g = 0; g < 4; g++)
            begin
                sg_reg[g] <= SG_W'(sq_reg[3*g]) + SG_W'(sq_reg[3*g+1])
                           + SG_W'(sq_reg[3*g+2]);
            end
            sumsq_reg <= SQ_W'(sg_reg[0]) + SQ_W'(sg_reg[1])
                       + SQ_W'(sg_reg[2]) + SQ_W'(sg_reg[3]);
            fd_reg    <= {fd_reg[1:0], found_reg};
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        mke_lane #(
            .ROOT  (k / 2),
            .MINOR (k % 2),
            .FRAC  (PROFILE_FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .c     (c_reg),
            .score (score[k])
        );
    end

    mke_merge #(
        .S_W    (B_W),
        .SIDE_W (SQ_W + 1)
    ) u_merge (
        .clk      (clk),
        .en       (en),
        .score    (score),
        .side_in  ({fd_reg[2], sumsq_reg}),
        .best     (best),
        .best_idx (best_idx),
        .side_out (mg_side)
    );

    mke_sqrt #(
        .SIDE_W (LANE_IDX_W + B_W + 1)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .x        (mg_side[SQ_W-1:0]),
        .side_in  ({mg_side[SQ_W], best_idx, best}),
        .root     (nrm),
        .side_out (sq_side)
    );

    mke_div #(
        .B_W    (B_W),
        .FRAC   (PROFILE_FRAC_BITS),
        .SIDE_W (LANE_IDX_W + 1)
    ) u_div (
        .clk      (clk),
        .en       (en),
        .best     (sq_side[B_W-1:0]),
        .nrm      (nrm),
        .side_in  (sq_side[LANE_IDX_W+B_W:B_W]),
        .conf     (conf),
        .side_out (dv_side)
    );

    assign m_tdata = dv_side[LANE_IDX_W]
                   ? {2'b00, conf, dv_side[0], dv_side[LANE_IDX_W-1:1], 1'b1}
                   : 24'd0;

endmodule

### tb/musical_key_estimator_test.sv
// Self-checking stream test for musical_key_estimator: chroma vectors in, key estimates
// compared against an in-bench key-profile correlator. Depends on mke_pkg and the RTL.
module musical_key_estimator_test import mke_pkg::*;;

    typedef logic [IN_W-1:0] chroma_vec_t [NUM_BINS];
    typedef struct packed {
        logic        found;
        logic [3:0]  root;
        logic        minor;
        logic [15:0] confidence;
    } key_est_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [NUM_BINS*IN_W-1:0] s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [23:0]              m_tdata;

    logic [63:0] major_prof [NUM_BINS];
    logic [63:0] minor_prof [NUM_BINS];
    key_est_t    expected_keys [$];
    int          mismatches;
    int          long_hold;

    musical_key_estimator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] b;
        x   = v;
        acc = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= acc + b)
            begin
                x   = x - (acc + b);
                acc = (acc >> 1) + b;
            end
            else
                acc = acc >> 1;
            b = b >> 2;
        end
        return acc;
    endfunction

    task automatic build_profiles();
        logic [63:0] smaj;
        logic [63:0] smin;
        logic [63:0] rmaj;
        logic [63:0] rmin;
        smaj = 0;
        smin = 0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            smaj += 64'(MAJOR_HUND[i]) * 64'(MAJOR_HUND[i]);
            smin += 64'(MINOR_HUND[i]) * 64'(MINOR_HUND[i]);
        end
        rmaj = root_of(smaj << 40);
        rmin = root_of(smin << 40);
        for (int i = 0; i < NUM_BINS; i++)
        begin
            major_prof[i] = ((64'(MAJOR_HUND[i]) << 36) + rmaj / 2) / rmaj;
            minor_prof[i] = ((64'(MINOR_HUND[i]) << 36) + rmin / 2) / rmin;
        end
    endtask

    function automatic key_est_t estimate_key(input chroma_vec_t v);
        key_est_t    k;
        logic [63:0] c [NUM_BINS];
        logic [63:0] peak;
        logic [63:0] sumsq;
        logic [63:0] smaj;
        logic [63:0] smin;
        logic [63:0] best;
        logic [63:0] nrm;
        logic [63:0] conf;
        int          top;
        k    = '0;
        peak = 0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            c[i] = 64'(v[i]);
            if (c[i] > peak)
                peak = c[i];
        end
        if (peak == 0)
            return k;
        top = 0;
        for (int b = 0; b < 64; b++)
            if (peak[b])
                top = b;
        sumsq = 0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            if (top > SCALE_TOP)
                c[i] = c[i] >> (top - SCALE_TOP);
            else
                c[i] = c[i] << (SCALE_TOP - top);
            sumsq += c[i] * c[i];
        end
        best = 0;
        for (int r = 0; r < NUM_BINS; r++)
        begin
            smaj = 0;
            smin = 0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                smaj += c[i] * major_prof[(i + NUM_BINS - r) % NUM_BINS];
                smin += c[i] * minor_prof[(i + NUM_BINS - r) % NUM_BINS];
            end
            if (r == 0 || smaj > best)
            begin
                best    = smaj;
                k.root  = 4'(r);
                k.minor = 1'b0;
            end
            if (smin > best)
            begin
                best    = smin;
                k.root  = 4'(r);
                k.minor = 1'b1;
            end
        end
        nrm = root_of(sumsq);
        if (nrm == 0)
            nrm = 1;
        conf = (best << 15) / (nrm << 16);
        if (conf > 64'(CONF_MAX))
            conf = 64'(CONF_MAX);
        k.found      = 1'b1;
        k.confidence = conf[15:0];
        return k;
    endfunction

    task automatic note_expected(input key_est_t k);
        expected_keys = {expected_keys, k};
    endtask

    task automatic send_chroma(input chroma_vec_t v);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        for (int i = 0; i < NUM_BINS; i++)
            s_tdata[i*IN_W +: IN_W] <= v[i];
        do
            @(posedge clk);
        while (!s_tready);
        note_expected(estimate_key(v));
    endtask

    initial
    begin
        key_est_t got;
        key_est_t want;
        int       stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3);
            if (long_hold > 0)
            begin
                stall     = long_hold;
                long_hold = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = '{found: m_tdata[0], root: m_tdata[4:1], minor: m_tdata[5],
                    confidence: m_tdata[21:6]};
            if (expected_keys.size() == 0)
            begin
                $error("unexpected result beat %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_keys.pop_front();
                if (got.found !== want.found)
                begin
                    $error("key_found: expected %0d, got %0d", want.found, got.found);
                    mismatches++;
                end
                if (got.root !== want.root)
                begin
                    $error("key_root: expected %0d, got %0d", want.root, got.root);
                    mismatches++;
                end
                if (got.minor !== want.minor)
                begin
                    $error("key_minor: expected %0d, got %0d", want.minor, got.minor);
                    mismatches++;
                end
                if (got.confidence !== want.confidence)
                begin
                    $error("key_confidence: expected %0d, got %0d",
                           want.confidence, got.confidence);
                    mismatches++;
                end
            end
        end
    end

    function automatic chroma_vec_t random_chroma();
        chroma_vec_t v;
        int          kind;
        int          width;
        int          rot;
        logic [31:0] gain;
        kind  = $urandom_range(0, 4);
        width = $urandom_range(1, 32);
        rot   = $urandom_range(0, NUM_BINS - 1);
        gain  = $urandom_range(1, 4000000);
        for (int i = 0; i < NUM_BINS; i++)
        begin
            case (kind)
                0: v[i] = $urandom;
                1: v[i] = 32'($urandom & ((64'd1 << width) - 1));
                2: v[i] = 32'((($urandom_range(0, 1) ? MINOR_HUND[(i + NUM_BINS - rot) % NUM_BINS]
                           : MAJOR_HUND[(i + NUM_BINS - rot) % NUM_BINS]) * (gain % 1000 + 1))
                          + $urandom_range(0, 200));
                3: v[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom & ((64'd1 << width) - 1))
                                                      : 32'd0;
                default: v[i] = gain;
            endcase
        end
        return v;
    endfunction

    task automatic test_extremes();
        chroma_vec_t v;
        for (int i = 0; i < NUM_BINS; i++)
            v[i] = '0;
        send_chroma(v);
        for (int i = 0; i < NUM_BINS; i++)
            v[i] = '1;
        send_chroma(v);
        for (int i = 0; i < NUM_BINS; i++)
            v[i] = 32'd1;
        send_chroma(v);
        for (int j = 0; j < NUM_BINS; j++)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                v[i] = (i == j) ? ((j % 2) ? 32'hffff_ffff : 32'd1) : 32'd0;
            send_chroma(v);
        end
    endtask

    task automatic test_profiles();
        chroma_vec_t v;
        for (int r = 0; r < NUM_BINS; r++)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                v[i] = 32'((r % 2) ? MINOR_HUND[(i + NUM_BINS - r) % NUM_BINS]
                                   : MAJOR_HUND[(i + NUM_BINS - r) % NUM_BINS]);
            send_chroma(v);
        end
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            send_chroma(random_chroma());
    endtask

    task automatic test_backpressure();
        long_hold = 300;
        for (int n = 0; n < 100; n++)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            do
                @(posedge clk);
            while (!s_tready);
            begin
                chroma_vec_t v;
                for (int i = 0; i < NUM_BINS; i++)
                    v[i] = s_tdata[i*IN_W +: IN_W];
                note_expected(estimate_key(v));
            end
        end
    endtask

    initial
    begin
        mismatches = 0;
        long_hold  = 0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        rst_n      = 1'b0;
        build_profiles();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_profiles();
        test_random(800);
        test_backpressure();
        test_random(800);
        s_tvalid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
